// ----- rtl/gqls_pkg.sv -----
// package for the grid q-learning step engine
// holds op codes, register indexes, action and reward codes and shared types; no dependencies
package gqls_pkg;
	localparam int GridCols = 16;
	localparam int GridRows = 8;
	localparam int QBits = 24;

	localparam logic [1:0] OP_MASK = 2'd0;
	localparam logic [1:0] OP_QWR = 2'd1;
	localparam logic [1:0] OP_STEP = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [2:0] REG_KEY_COL = 3'd0;
	localparam logic [2:0] REG_KEY_ROW = 3'd1;
	localparam logic [2:0] REG_GOAL_COL = 3'd2;
	localparam logic [2:0] REG_GOAL_ROW = 3'd3;
	localparam logic [2:0] REG_START_COL = 3'd4;
	localparam logic [2:0] REG_START_ROW = 3'd5;
	localparam logic [2:0] REG_LEARN = 3'd6;
	localparam logic [2:0] REG_DISCOUNT = 3'd7;

	localparam logic [1:0] ACT_UP = 2'd0;
	localparam logic [1:0] ACT_DOWN = 2'd1;
	localparam logic [1:0] ACT_RIGHT = 2'd2;
	localparam logic [1:0] ACT_LEFT = 2'd3;

	localparam logic [1:0] RW_NONE = 2'd0;
	localparam logic [1:0] RW_KEY = 2'd1;
	localparam logic [1:0] RW_GOAL = 2'd2;
	localparam logic [1:0] RW_GOAL_KEY = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // latch input item, read current-cell q
		logic rd_cur;   // pick action, move, read successor q
		logic rd_next;  // pick successor best, read its q
		logic mul_t;    // t = r + g*qn
		logic mul_u;    // lr*(t-q)
		logic finish;   // write back, commit state, present result
	} gqls_cmd_t;

	typedef struct packed {
		logic is_step;
	} gqls_sts_t;
endpackage

// ----- rtl/gqls_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module gqls_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/gqls_ctrl.sv -----
// sequencer for the q-learning step engine
// depends on gqls_pkg
module gqls_ctrl import gqls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gqls_sts_t sts,
	output logic      busy,
	output gqls_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CUR = 3'd1;
	localparam logic [2:0] S_NEXT = 3'd2;
	localparam logic [2:0] S_MT = 3'd3;
	localparam logic [2:0] S_MU = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_CUR;
				end
			end
			S_CUR: begin
				if (sts.is_step) begin
					cmd.rd_cur = 1'b1;
					state_d = S_NEXT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_NEXT: begin
				cmd.rd_next = 1'b1;
				state_d = S_MT;
			end
			S_MT: begin
				cmd.mul_t = 1'b1;
				state_d = S_MU;
			end
			S_MU: begin
				cmd.mul_u = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	a_fin_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy) else $error("no return to idle");
	a_onehot_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("overlapping commands");
`endif
endmodule

// ----- rtl/gqls_dp.sv -----
// datapath: position state, mask and q memories, action choice and q update
// depends on gqls_pkg and gqls_ram
module gqls_dp import gqls_pkg::*; #(
	parameter int GRID_COLS = GridCols,
	parameter int GRID_ROWS = GridRows,
	parameter int Q_BITS = QBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gqls_cmd_t          cmd,
	output gqls_sts_t          sts,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         op,
	input  logic [3:0]         cell_col,
	input  logic [2:0]         cell_row,
	input  logic               key_held,
	input  logic [1:0]         action,
	input  logic signed [23:0] q_value,
	input  logic [3:0]         move_mask,
	input  logic               explore,
	output logic               done,
	output logic [3:0]         pos_col,
	output logic [2:0]         pos_row,
	output logic               key_flag,
	output logic [1:0]         action_taken,
	output logic [1:0]         reward_code,
	output logic signed [23:0] new_q,
	output logic               moved,
	output logic               episode_done
);
	localparam int Cells = GRID_COLS * GRID_ROWS;
	localparam int CA = $clog2(Cells);
	localparam int QDepth = Cells * 8;
	localparam int QRow = Q_BITS * 4;
	localparam int TW = Q_BITS + 7;  // t and t-q width
	localparam logic signed [Q_BITS-1:0] QMax = {1'b0, {(Q_BITS-1){1'b1}}};
	localparam logic signed [Q_BITS-1:0] QMin = {1'b1, {(Q_BITS-1){1'b0}}};

	// config registers
	logic [3:0] key_col_q, goal_col_q, start_col_q;
	logic [2:0] key_row_q, goal_row_q, start_row_q;
	logic [15:0] lr_q, disc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_col_q <= 4'd8; key_row_q <= 3'd2;
			goal_col_q <= 4'd8; goal_row_q <= 3'd0;
			start_col_q <= 4'd4; start_row_q <= 3'd2;
			lr_q <= 16'd13107; disc_q <= 16'd58982;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_COL: key_col_q <= cfg_data[3:0];
				REG_KEY_ROW: key_row_q <= cfg_data[2:0];
				REG_GOAL_COL: goal_col_q <= cfg_data[3:0];
				REG_GOAL_ROW: goal_row_q <= cfg_data[2:0];
				REG_START_COL: start_col_q <= cfg_data[3:0];
				REG_START_ROW: start_row_q <= cfg_data[2:0];
				REG_LEARN: lr_q <= cfg_data;
				REG_DISCOUNT: disc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched item
	logic [1:0] op_q, ain_q;
	logic [3:0] ccol_q, mm_q;
	logic [2:0] crow_q;
	logic kh_q, ex_q;
	logic signed [23:0] qv_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; ccol_q <= cell_col; crow_q <= cell_row; kh_q <= key_held;
			ain_q <= action; qv_q <= q_value; mm_q <= move_mask; ex_q <= explore;
		end
	end
	assign sts.is_step = (op_q == OP_STEP);

	// position state
	logic [3:0] cur_col_q;
	logic [2:0] cur_row_q;
	logic cur_key_q;

	function automatic logic in_grid(input logic [4:0] c, input logic [3:0] r);
		return ({27'd0, c} < GRID_COLS) && ({28'd0, r} < GRID_ROWS);
	endfunction

	function automatic logic [CA-1:0] cidx(input logic [3:0] c, input logic [2:0] r);
		logic [31:0] i;
		i = {29'd0, r} * GRID_COLS + {28'd0, c};
		return i[CA-1:0];
	endfunction

	// mask store: ram plus a valid bit per cell so unwritten cells read as no moves
	// read at the current cell while idle, at the candidate cell during rd_cur
	logic [CA-1:0] mask_addr;
	logic mask_addr_ok, mask_ok_q, mask_we;
	logic [3:0] mask_rdata, m_rd;
	logic [Cells-1:0] mval_q;
	logic [3:0] nc_s, cand_c;
	logic [2:0] nr_s, cand_r;
	logic nk_s, nk_c;

	assign mask_we = cmd.finish && op_q == OP_MASK
		&& in_grid({1'b0, ccol_q}, {1'b0, crow_q});

	always_comb begin
		mask_addr = cidx(cur_col_q, cur_row_q);
		mask_addr_ok = in_grid({1'b0, cur_col_q}, {1'b0, cur_row_q});
		if (cmd.rd_cur) begin
			mask_addr = cidx(cand_c, cand_r);
			mask_addr_ok = in_grid({1'b0, cand_c}, {1'b0, cand_r});
		end else if (mask_we) begin
			mask_addr = cidx(ccol_q, crow_q);
			mask_addr_ok = 1'b1;
		end
	end

	gqls_ram #(.Width(4), .Depth(Cells)) u_mask (
		.clk(clk), .we(mask_we), .addr(mask_addr), .wdata(mm_q), .rdata(mask_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mval_q <= '0;
			mask_ok_q <= 1'b0;
		end else begin
			mask_ok_q <= mask_addr_ok && mval_q[mask_addr];
			if (mask_we) mval_q[mask_addr] <= 1'b1;
		end
	end
	assign m_rd = mask_ok_q ? mask_rdata : 4'd0;

	// q store: one row of four actions per cell and key half
	logic [CA:0] q_addr, row_cur, row_nxt, row_wr;
	logic [QRow-1:0] q_wdata, q_rdata, row_cur_s;
	logic [3:0] q_lane_we;

	assign row_cur = {cidx(cur_col_q, cur_row_q), cur_key_q};
	assign row_nxt = {cidx(cand_c, cand_r), nk_c};
	assign row_wr = {cidx(ccol_q, crow_q), kh_q};

	logic signed [Q_BITS-1:0] qw_sat, nq_s;
	logic [1:0] a_s;

	always_comb begin
		q_addr = row_cur;
		if (cmd.rd_cur) q_addr = row_nxt;
		else if (cmd.finish && op_q == OP_QWR) q_addr = row_wr;
		else if (cmd.finish) q_addr = row_cur;
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_lane
			gqls_ram #(.Width(Q_BITS), .Depth(QDepth / 4)) u_lane (
				.clk(clk), .we(q_lane_we[g]), .addr(q_addr),
				.wdata(q_wdata[g*Q_BITS +: Q_BITS]),
				.rdata(q_rdata[g*Q_BITS +: Q_BITS])
			);
		end
	endgenerate

	always_comb begin
		q_lane_we = 4'd0;
		if (cmd.finish && op_q == OP_QWR && in_grid({1'b0, ccol_q}, {1'b0, crow_q})) begin
			q_lane_we[ain_q] = 1'b1;
		end else if (cmd.finish && op_q == OP_STEP
			&& in_grid({1'b0, cur_col_q}, {1'b0, cur_row_q})) begin
			q_lane_we[a_s] = 1'b1;
		end
	end
	always_comb begin
		for (int i = 0; i < 4; i++)
			q_wdata[i*Q_BITS +: Q_BITS] = (op_q == OP_QWR) ? qw_sat : nq_s;
	end

	// saturate a 24-bit write to Q_BITS
	always_comb begin
		logic signed [31:0] v;
		v = 32'(qv_q);
		if (v > 32'(QMax)) qw_sat = QMax;
		else if (v < 32'(QMin)) qw_sat = QMin;
		else qw_sat = v[Q_BITS-1:0];
	end

	// greedy choice over a row
	function automatic logic [1:0] greedy(input logic [3:0] m, input logic [QRow-1:0] row);
		logic [1:0] best;
		logic have;
		logic signed [Q_BITS-1:0] bv, v;
		best = 2'd0; have = 1'b0; bv = '0;
		for (int a = 0; a < 4; a++) begin
			v = row[a*Q_BITS +: Q_BITS];
			if (m[a] && (!have || v > bv)) begin
				bv = v; best = 2'(a); have = 1'b1;
			end
		end
		return best;
	endfunction

	// action choice and move, from the current row (read during load)
	logic [1:0] a_c, a_ex;
	logic mv_c;
	logic [4:0] tc;
	logic [3:0] tr;
	always_comb begin
		a_ex = ain_q;
		for (int i = 3; i >= 0; i--)
			if (m_rd[2'(ain_q + 2'(i))]) a_ex = 2'(ain_q + 2'(i));
		a_c = ex_q ? a_ex : greedy(m_rd, q_rdata);
		tc = {1'b0, cur_col_q};
		tr = {1'b0, cur_row_q};
		unique case (a_c)
			ACT_UP: tr = tr - 4'd1;
			ACT_DOWN: tr = tr + 4'd1;
			ACT_RIGHT: tc = tc + 5'd1;
			ACT_LEFT: tc = tc - 5'd1;
			default: ;
		endcase
		mv_c = m_rd[a_c] && in_grid(tc, tr);
		cand_c = mv_c ? tc[3:0] : cur_col_q;
		cand_r = mv_c ? tr[2:0] : cur_row_q;
		nk_c = cur_key_q | (mv_c && cand_c == key_col_q && cand_r == key_row_q);
	end

	logic mv_s;
	logic [1:0] rew_s;
	logic signed [Q_BITS-1:0] q_s, qn_s;
	logic signed [TW-1:0] t_s;
	logic signed [TW+17:0] u_s;

	always_ff @(posedge clk) begin
		if (cmd.rd_cur) begin
			a_s <= a_c; mv_s <= mv_c;
			nc_s <= cand_c; nr_s <= cand_r; nk_s <= nk_c;
			row_cur_s <= q_rdata;
			if (cand_c == key_col_q && cand_r == key_row_q && !cur_key_q) rew_s <= RW_KEY;
			else if (cand_c == goal_col_q && cand_r == goal_row_q)
				rew_s <= cur_key_q ? RW_GOAL_KEY : RW_GOAL;
			else rew_s <= RW_NONE;
		end
		if (cmd.rd_next) begin
			q_s <= in_grid({1'b0, cur_col_q}, {1'b0, cur_row_q})
				? row_cur_s[a_s*Q_BITS +: Q_BITS] : '0;
			qn_s <= in_grid({1'b0, nc_s}, {1'b0, nr_s})
				? q_rdata[greedy(m_rd, q_rdata)*Q_BITS +: Q_BITS] : '0;
		end
	end

	// t = r + floor(g*qn/65536); u = floor(lr*(t-q)/65536)
	logic signed [Q_BITS+17:0] gp;
	logic signed [TW-1:0] rv;
	always_comb begin
		gp = $signed({1'b0, disc_q}) * qn_s;
		unique case (rew_s)
			RW_KEY: rv = TW'(3 * 4096);
			RW_GOAL: rv = TW'(5 * 4096);
			RW_GOAL_KEY: rv = TW'(25 * 4096);
			default: rv = '0;
		endcase
	end
	logic signed [TW+17:0] up;
	logic signed [TW-1:0] dq;
	assign dq = t_s - TW'(q_s);
	assign up = $signed({1'b0, lr_q}) * dq;

	always_ff @(posedge clk) begin
		if (cmd.mul_t) t_s <= rv + TW'(gp >>> 16);
		if (cmd.mul_u) u_s <= up >>> 16;
	end

	always_comb begin
		logic signed [TW+17:0] s;
		s = u_s + (TW+18)'(q_s);
		if (s > (TW+18)'(QMax)) nq_s = QMax;
		else if (s < (TW+18)'(QMin)) nq_s = QMin;
		else nq_s = s[Q_BITS-1:0];
	end

	// state commit and result register
	logic [3:0] pc_d;
	logic [2:0] pr_d;
	logic pk_d;
	always_comb begin
		pc_d = cur_col_q; pr_d = cur_row_q; pk_d = cur_key_q;
		if (op_q == OP_STEP) begin
			pc_d = nc_s; pr_d = nr_s; pk_d = nk_s;
		end else if (op_q == OP_RESTART) begin
			pc_d = start_col_q; pr_d = start_row_q; pk_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 4'd4; cur_row_q <= 3'd2; cur_key_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.finish) begin
				cur_col_q <= pc_d; cur_row_q <= pr_d; cur_key_q <= pk_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pos_col <= pc_d; pos_row <= pr_d; key_flag <= pk_d;
			episode_done <= (pc_d == goal_col_q) && (pr_d == goal_row_q);
			action_taken <= (op_q == OP_STEP) ? a_s : 2'd0;
			reward_code <= (op_q == OP_STEP) ? rew_s : RW_NONE;
			moved <= (op_q == OP_STEP) && mv_s;
			if (op_q == OP_STEP) new_q <= 24'(nq_s);
			else if (op_q == OP_QWR && in_grid({1'b0, ccol_q}, {1'b0, crow_q}))
				new_q <= 24'(qw_sat);
			else new_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_move_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && moved |-> action_taken == $past(a_s)) else $error("action mismatch");
	a_key_keep: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cur_key_q) && $past(op_q) == OP_STEP |-> key_flag)
		else $error("key flag dropped");
	a_wr_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(q_lane_we)) else $error("multiple lanes written");
`endif
endmodule

// ----- rtl/grid_q_learning_step.sv -----
// top level of the grid q-learning step engine
// depends on gqls_pkg, gqls_ctrl, gqls_dp (and gqls_ram through gqls_dp)
//
// usage: raise start with an item on op and the cell/action/value ports;
// the item is taken when start is high and busy is low. busy stays high
// until the result appears for one cycle with strobe high.
// sequence: a step reads the q row of the current cell, then the successor
// row, does two registered multiplies (t, then u) and writes back; mask
// writes, q writes and restarts go straight to the write-back.
// busy falls in the strobe cycle, so a new item can be taken at the edge
// that ends it; no new item is taken while one is still in progress.
// the q memory is one row of four actions per cell and key half, read with
// one port, which sets the step length.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, write only while idle.
// reset: position at the start cell, key flag clear, all masks zero, config
// at reset values; q entries are undefined until written.
// the receiver cannot stall: the strobe cycle is the only chance to take it.
module grid_q_learning_step import gqls_pkg::*; #(
	parameter int GRID_COLS = GridCols,
	parameter int GRID_ROWS = GridRows,
	parameter int Q_BITS = QBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         op,
	input  logic [3:0]         cell_col,
	input  logic [2:0]         cell_row,
	input  logic               key_held,
	input  logic [1:0]         action,
	input  logic signed [23:0] q_value,
	input  logic [3:0]         move_mask,
	input  logic               explore,
	output logic               strobe,
	output logic [3:0]         pos_col,
	output logic [2:0]         pos_row,
	output logic               key_flag,
	output logic [1:0]         action_taken,
	output logic [1:0]         reward_code,
	output logic signed [23:0] new_q,
	output logic               moved,
	output logic               episode_done
);
	gqls_cmd_t cmd;
	gqls_sts_t sts;
	logic ctrl_busy;

	assign cfg_ready = 1'b1;
	// busy drops in the strobe cycle; a load there leaves the result registers alone
	assign busy = ctrl_busy;

	gqls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.busy(ctrl_busy), .cmd(cmd)
	);

	gqls_dp #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .Q_BITS(Q_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .cell_col(cell_col), .cell_row(cell_row), .key_held(key_held),
		.action(action), .q_value(q_value), .move_mask(move_mask), .explore(explore),
		.done(strobe), .pos_col(pos_col), .pos_row(pos_row), .key_flag(key_flag),
		.action_taken(action_taken), .reward_code(reward_code), .new_q(new_q),
		.moved(moved), .episode_done(episode_done)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item not taken");
	a_strobe_after: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !$past(strobe)) else $error("double result");
	a_idle_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");
`endif
endmodule
